/* rtl/usx_pkg.sv */
// Shared types, constants and helper functions for the UTF-8 sanitizer.
package usx_pkg;

  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] LEAD_LO   = 8'hC2;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD_HI   = 8'hF4;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] SEC_E0_LO = 8'hA0;
  localparam logic [7:0] SEC_ED_HI = 8'h9F;
  localparam logic [7:0] SEC_F0_LO = 8'h90;
  localparam logic [7:0] SEC_F4_HI = 8'h8F;

  localparam logic [20:0] CP_LOW_LIMIT  = 21'h00008D;
  localparam logic [20:0] CP_HIGH_LIMIT = 21'h00009F;
  localparam logic [20:0] CP_NONCHAR_LO = 21'h00FDD0;
  localparam logic [20:0] CP_NONCHAR_HI = 21'h00FDEF;

  localparam logic [7:0] CH_OPEN  = 8'h3C; // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E; // '>'

  localparam logic [1:0] ESC_OPEN  = 2'd0;
  localparam logic [1:0] ESC_HI    = 2'd1;
  localparam logic [1:0] ESC_LO    = 2'd2;
  localparam logic [1:0] ESC_CLOSE = 2'd3;

  localparam int HELD_DEPTH = 3;
  localparam int UNIT_DEPTH = 4;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // input beat taken: plan the step and update scan state
    logic advance;  // output beat taken: move to the next character
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic plan_nonempty; // the byte just offered causes at least one output
    logic step_last;     // current output beat is the last of its step
  } sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h37 + {4'd0, nib};
    end
    return ch;
  endfunction

  function automatic logic cp_ok(input logic [20:0] cp);
    logic ok;
    if (cp < CP_LOW_LIMIT) begin
      ok = 1'b1;
    end else begin
      ok = (cp > CP_HIGH_LIMIT) && (cp[15:1] != 15'h7FFF) &&
           ((cp < CP_NONCHAR_LO) || (cp > CP_NONCHAR_HI));
    end
    return ok;
  endfunction

endpackage

/* rtl/utf8_sanitize_hex_escape.sv */
// Top level of the UTF-8 sanitizer with hex escapes.
//
// Input channel: one raw byte per beat (in_byte, end_of_text), in_valid/in_ready.
// Output channel: one sanitized byte per beat (out_byte, run_last, text_done,
// any_replaced), out_valid/out_ready.
// Printable ASCII and accepted UTF-8 sequences pass unchanged; any other byte
// that starts a scan leaves as '<HH>' in uppercase hex.
// An input beat is taken only while the block is idle. Its outputs then follow,
// one per cycle while out_ready is high, from the cycle after, from a buffer of
// up to four units (a raw byte or a four-character escape), so a step yields 0
// to 16 beats. The output sequencer holds off the input until the step's last
// beat is taken. Bytes of a pending multi-byte sequence give no output.
// A stalled receiver simply holds the current output beat; nothing is lost.
// Reset (rst, synchronous) empties the pending sequence, clears the replaced
// flag and returns to idle. End of text empties the pending sequence when its
// byte is taken, and clears the flag and returns to idle after its last beat.
module utf8_sanitize_hex_escape (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       text_done,
  output logic       any_replaced
);

  usx_pkg::cmd_t cmd;
  usx_pkg::sts_t sts;

  // sequence the beats: take an input, then drain its outputs
  usx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // scan state, unit buffer and escape expansion
  usx_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .end_of_text  (end_of_text),
    .cmd          (cmd),
    .sts          (sts),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .text_done    (text_done),
    .any_replaced (any_replaced)
  );

endmodule

/* rtl/usx_ctrl.sv */
// Controller state machine: input acceptance and output beat sequencing.
module usx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  usx_pkg::sts_t sts,
  output usx_pkg::cmd_t cmd
);

  usx_pkg::state_t state;
  usx_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= usx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    unique case (state)
      usx_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && sts.plan_nonempty) begin
          state_next = usx_pkg::S_EMIT;
        end
      end
      usx_pkg::S_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
        // drop back to idle once the final beat of the step is taken
        if (out_ready && sts.step_last) begin
          state_next = usx_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = usx_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/usx_dp.sv */
// Datapath: scan state, step planning, output unit buffer and escape expansion.
module usx_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  logic          end_of_text,
  input  usx_pkg::cmd_t cmd,
  output usx_pkg::sts_t sts,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          text_done,
  output logic          any_replaced
);

  // scan state
  logic [7:0]  held [usx_pkg::HELD_DEPTH];
  logic [1:0]  held_count, held_count_next;
  logic [2:0]  seq_len, seq_len_next;
  logic [20:0] cp_acc, cp_acc_next;
  logic        held_wr;
  logic [1:0]  held_wr_idx;

  // output unit buffer
  logic [7:0]  unit_byte [usx_pkg::UNIT_DEPTH];
  logic        unit_esc  [usx_pkg::UNIT_DEPTH];
  logic [2:0]  unit_count;
  logic [1:0]  unit_idx;
  logic [1:0]  char_idx;
  logic        text_end;
  logic        replaced;

  // planning
  logic        is_print, is_lead, fresh_hold, fresh_esc;
  logic [7:0]  sec_lo, sec_hi;
  logic        sec_ok, cont_ok, byte_ok, complete, code_ok;
  logic [20:0] cp_next;
  logic [2:0]  lead_len;
  logic [20:0] lead_acc;
  logic [1:0]  plan_held;
  logic        plan_held_esc, plan_inc, plan_esc;
  logic [2:0]  plan_count;

  // emission
  logic [7:0]  cur_byte;
  logic        cur_esc;
  logic        unit_last;
  logic        step_last;

  always_comb begin
    is_print   = (in_byte >= usx_pkg::PRINT_LO) && (in_byte <= usx_pkg::PRINT_HI);
    is_lead    = (in_byte >= usx_pkg::LEAD_LO) && (in_byte <= usx_pkg::LEAD_HI);
    fresh_hold = is_lead && !end_of_text;
    fresh_esc  = !is_print;

    if (in_byte < usx_pkg::LEAD3_LO) begin
      lead_len = 3'd2;
      lead_acc = {16'd0, in_byte[4:0]};
    end else if (in_byte < usx_pkg::LEAD4_LO) begin
      lead_len = 3'd3;
      lead_acc = {17'd0, in_byte[3:0]};
    end else begin
      lead_len = 3'd4;
      lead_acc = {18'd0, in_byte[2:0]};
    end

    sec_lo = usx_pkg::CONT_LO;
    sec_hi = usx_pkg::CONT_HI;
    priority if (held[0] == usx_pkg::LEAD_E0) begin
      sec_lo = usx_pkg::SEC_E0_LO;
    end else if (held[0] == usx_pkg::LEAD_ED) begin
      sec_hi = usx_pkg::SEC_ED_HI;
    end else if (held[0] == usx_pkg::LEAD_F0) begin
      sec_lo = usx_pkg::SEC_F0_LO;
    end else if (held[0] == usx_pkg::LEAD_F4) begin
      sec_hi = usx_pkg::SEC_F4_HI;
    end else begin
      sec_lo = usx_pkg::CONT_LO;
    end
    sec_ok   = (in_byte >= sec_lo) && (in_byte <= sec_hi);
    cont_ok  = (in_byte[7:6] == 2'b10);
    byte_ok  = (held_count == 2'd1) ? sec_ok : cont_ok;
    cp_next  = {cp_acc[14:0], in_byte[5:0]};
    complete = ({1'b0, held_count} + 3'd1) >= seq_len;
    code_ok  = usx_pkg::cp_ok(cp_next);

    plan_held       = 2'd0;
    plan_held_esc   = 1'b1;
    plan_inc        = 1'b0;
    plan_esc        = 1'b1;
    held_count_next = 2'd0;
    seq_len_next    = 3'd0;
    cp_acc_next     = 21'd0;
    held_wr         = 1'b0;
    held_wr_idx     = 2'd0;

    priority if (held_count == 2'd0 || !byte_ok) begin
      // escape whatever was pending, then scan the byte afresh
      plan_held = held_count;
      plan_inc  = !fresh_hold;
      plan_esc  = fresh_esc;
      if (fresh_hold) begin
        held_wr         = 1'b1;
        held_count_next = 2'd1;
        seq_len_next    = lead_len;
        cp_acc_next     = lead_acc;
      end
    end else if (complete) begin
      plan_held     = held_count;
      plan_held_esc = !code_ok;
      plan_inc      = 1'b1;
      plan_esc      = !code_ok;
    end else if (end_of_text) begin
      // sequence cut off by the end of the text
      plan_held = held_count;
      plan_inc  = 1'b1;
    end else begin
      held_wr         = 1'b1;
      held_wr_idx     = held_count;
      held_count_next = held_count + 2'd1;
      seq_len_next    = seq_len;
      cp_acc_next     = cp_next;
    end

    if (end_of_text) begin
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      cp_acc_next     = 21'd0;
    end

    plan_count = {1'b0, plan_held} + {2'd0, plan_inc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len    <= 3'd0;
      cp_acc     <= 21'd0;
    end else if (cmd.load) begin
      held_count <= held_count_next;
      seq_len    <= seq_len_next;
      cp_acc     <= cp_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && held_wr) begin
      held[held_wr_idx] <= in_byte;
    end
  end

  // latch the step's output units: pending bytes first, then the new byte
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < usx_pkg::HELD_DEPTH; i++) begin
        if (2'(i) < plan_held) begin
          unit_byte[i] <= held[i];
          unit_esc[i]  <= plan_held_esc;
        end else begin
          unit_byte[i] <= in_byte;
          unit_esc[i]  <= plan_esc;
        end
      end
      unit_byte[usx_pkg::HELD_DEPTH] <= in_byte;
      unit_esc[usx_pkg::HELD_DEPTH]  <= plan_esc;
      unit_count <= plan_count;
      text_end   <= end_of_text;
    end
  end

  always_comb begin
    cur_byte  = unit_byte[unit_idx];
    cur_esc   = unit_esc[unit_idx];
    unit_last = !cur_esc || (char_idx == usx_pkg::ESC_CLOSE);
    step_last = unit_last && (({1'b0, unit_idx} + 3'd1) == unit_count);

    out_byte = cur_byte;
    if (cur_esc) begin
      unique case (char_idx)
        usx_pkg::ESC_OPEN:  out_byte = usx_pkg::CH_OPEN;
        usx_pkg::ESC_HI:    out_byte = usx_pkg::hex_char(cur_byte[7:4]);
        usx_pkg::ESC_LO:    out_byte = usx_pkg::hex_char(cur_byte[3:0]);
        usx_pkg::ESC_CLOSE: out_byte = usx_pkg::CH_CLOSE;
        default:            out_byte = cur_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_idx <= 2'd0;
      char_idx <= 2'd0;
    end else if (cmd.load) begin
      unit_idx <= 2'd0;
      char_idx <= 2'd0;
    end else if (cmd.advance) begin
      if (unit_last) begin
        unit_idx <= unit_idx + 2'd1;
        char_idx <= 2'd0;
      end else begin
        char_idx <= char_idx + 2'd1;
      end
    end
  end

  // replaced flag: set by the first escape, clear after the text's last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      replaced <= 1'b0;
    end else if (cmd.advance) begin
      if (step_last && text_end) begin
        replaced <= 1'b0;
      end else if (cur_esc) begin
        replaced <= 1'b1;
      end
    end
  end

  assign run_last          = step_last;
  assign text_done         = step_last && text_end;
  assign any_replaced      = replaced || cur_esc;
  assign sts.plan_nonempty = (plan_count != 3'd0);
  assign sts.step_last     = step_last;

endmodule
